>>> sv/tsp_pkg.sv
// Shared types and constants for the exhaustive tour search block.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
package tsp_pkg;
	localparam int MAX_CITIES = 8;
	localparam int DIST_WIDTH = 16;
	localparam int CITY_W = $clog2(MAX_CITIES);
	localparam int ADDR_W = $clog2(MAX_CITIES * MAX_CITIES);
	localparam int CNT_W = $clog2(MAX_CITIES + 1);
	localparam int COST_W = DIST_WIDTH + CNT_W;
	localparam int LOAD_W = ADDR_W + 1;
	localparam int OUT_COST_W = 19;

	typedef logic [CITY_W-1:0] city_t;

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_INIT  = 7'b0000010,
		ST_COST  = 7'b0000100,
		ST_CMP   = 7'b0001000,
		ST_FIND  = 7'b0010000,
		ST_PERM  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load_we;
		logic init;
		logic cost_clear;
		logic cost_step;
		logic compare;
		logic find_step;
		logic permute;
		logic emit_step;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic load_done;
		logic cost_done;
		logic find_done;
		logic no_next;
		logic emit_last;
	} stat_t;
endpackage

>>> sv/tsp_ctrl.sv
// Controller state machine for the tour search block.
// Depends on tsp_pkg.
`timescale 1ns / 1ps
module tsp_ctrl import tsp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	output logic   out_valid,
	input  logic   out_ready,
	input  stat_t  stat,
	output cmd_t   cmd
);
	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load_we = in_valid;
				if (in_valid && stat.load_done) state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d = ST_COST;
			end
			ST_COST: begin
				cmd.cost_step = 1'b1;
				if (stat.cost_done) state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d = ST_FIND;
			end
			ST_FIND: begin
				if (stat.no_next) begin
					state_d = ST_EMIT;
				end else if (stat.find_done) begin
					state_d = ST_PERM;
				end else begin
					cmd.find_step = 1'b1;
				end
			end
			ST_PERM: begin
				cmd.permute = 1'b1;
				cmd.cost_clear = 1'b1;
				state_d = ST_COST;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.emit_step = 1'b1;
					if (stat.emit_last) state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("load and emit overlap");
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && stat.emit_last) |=> in_ready)
		else $error("no return to load after last city");
endmodule

>>> sv/tsp_dp.sv
// Datapath: distance memory, tour registers, cost accumulator, permutation step.
// Depends on tsp_pkg.
`timescale 1ns / 1ps
module tsp_dp import tsp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [3:0]             cfg_data,
	input  logic [15:0]            distance,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	output logic [2:0]             tour_city,
	output logic [OUT_COST_W-1:0]  best_cost,
	output logic                   last_city
);
	logic [DIST_WIDTH-1:0] mem [MAX_CITIES*MAX_CITIES];
	logic [DIST_WIDTH-1:0] rd_q;
	logic [3:0]            ncfg_q;
	logic [CNT_W-1:0]      n;
	logic [LOAD_W-1:0]     load_q;
	city_t                 cur_q [MAX_CITIES];
	city_t                 best_q [MAX_CITIES];
	logic [COST_W-1:0]     run_q, best_total_q;
	logic                  first_q;
	// Cost walk: pos_q is the edge being addressed; rd_v_q marks valid read data.
	logic [CNT_W-1:0]      pos_q;
	logic                  rd_v_q;
	logic [CNT_W-1:0]      fi_q;   // pivot search index i (tour[i-1] < tour[i])
	logic [CNT_W-1:0]      piv;
	logic [CNT_W-1:0]      emit_q;
	logic [CNT_W-1:0]      nxt;
	logic [ADDR_W-1:0]     rd_addr;
	logic [2*CNT_W-1:0]    prod;
	logic [2*CNT_W-1:0]    nn;
	logic                  walking;
	// Rightmost suffix element larger than the pivot (suffix is descending).
	city_t                 succ;
	logic [CNT_W-1:0]      sj;

	always_comb begin
		if (ncfg_q < 4'd2) n = CNT_W'(2);
		else if (ncfg_q > 4'(MAX_CITIES)) n = CNT_W'(MAX_CITIES);
		else n = CNT_W'(ncfg_q);
	end

	assign nn = (2*CNT_W)'(n) * (2*CNT_W)'(n);
	assign nxt = (pos_q + 1'b1 == n) ? '0 : pos_q + 1'b1;
	assign prod = (2*CNT_W)'(cur_q[pos_q[CITY_W-1:0]]) * (2*CNT_W)'(n)
		+ (2*CNT_W)'(cur_q[nxt[CITY_W-1:0]]);
	assign rd_addr = prod[ADDR_W-1:0];
	assign walking = cmd.cost_step && (pos_q < n);
	assign piv = fi_q - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load_we) mem[load_q[ADDR_W-1:0]] <= distance[DIST_WIDTH-1:0];
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncfg_q <= 4'd8;
			load_q <= '0;
			pos_q <= '0;
			rd_v_q <= 1'b0;
			run_q <= '0;
			best_total_q <= '0;
			first_q <= 1'b0;
			fi_q <= '0;
			emit_q <= '0;
			for (int k = 0; k < MAX_CITIES; k++) begin
				cur_q[k] <= city_t'(k);
				best_q[k] <= city_t'(k);
			end
		end else begin
			if (cfg_we) begin
				ncfg_q <= cfg_data;
				load_q <= '0;
			end else if (cmd.load_we) begin
				if ((2*CNT_W)'(load_q) + 1'b1 >= nn) load_q <= '0;
				else load_q <= load_q + 1'b1;
			end
			if (cmd.init || cmd.cost_clear) begin
				pos_q <= '0;
				rd_v_q <= 1'b0;
				run_q <= '0;
			end
			if (cmd.init) begin
				first_q <= 1'b1;
				emit_q <= '0;
				for (int k = 0; k < MAX_CITIES; k++) begin
					cur_q[k] <= city_t'(k);
					best_q[k] <= city_t'(k);
				end
			end
			if (cmd.cost_step) begin
				rd_v_q <= walking;
				if (walking) pos_q <= pos_q + 1'b1;
				if (rd_v_q) run_q <= run_q + COST_W'(rd_q);
			end
			if (cmd.compare) begin
				first_q <= 1'b0;
				fi_q <= n - 1'b1;
				if (first_q || run_q < best_total_q) begin
					best_total_q <= run_q;
					for (int k = 0; k < MAX_CITIES; k++) best_q[k] <= cur_q[k];
				end
			end
			if (cmd.find_step) fi_q <= fi_q - 1'b1;
			if (cmd.permute) begin
				// Swap pivot with rightmost larger element, then reverse the suffix.
				for (int k = 0; k < MAX_CITIES; k++) begin
					if (CNT_W'(k) == piv) begin
						cur_q[k] <= succ;
					end else if (CNT_W'(k) >= fi_q && CNT_W'(k) < n) begin
						if (CNT_W'(int'(n) - 1 - k + int'(fi_q)) == sj)
							cur_q[k] <= cur_q[piv[CITY_W-1:0]];
						else
							cur_q[k] <= cur_q[CITY_W'(int'(n) - 1 - k + int'(fi_q))];
					end
				end
			end
			if (cmd.emit_step) begin
				if (stat.emit_last) emit_q <= '0;
				else emit_q <= emit_q + 1'b1;
			end
		end
	end

	always_comb begin
		succ = '0;
		sj = '0;
		for (int k = 0; k < MAX_CITIES; k++) begin
			if (CNT_W'(k) >= fi_q && CNT_W'(k) < n && cur_q[k] > cur_q[piv[CITY_W-1:0]]) begin
				succ = cur_q[k];
				sj = CNT_W'(k);
			end
		end
	end

	assign stat.load_done = ((2*CNT_W)'(load_q) + 1'b1 >= nn) && !cfg_we;
	assign stat.cost_done = (pos_q == n) && !rd_v_q;
	assign stat.no_next = (fi_q == '0);
	assign stat.find_done = (fi_q != '0) &&
		(cur_q[piv[CITY_W-1:0]] < cur_q[fi_q[CITY_W-1:0]]);
	assign stat.emit_last = (emit_q + 1'b1 == n);

	assign tour_city = 3'(best_q[emit_q[CITY_W-1:0]]);
	assign best_cost = OUT_COST_W'(best_total_q);
	assign last_city = stat.emit_last;

	a_pos: assert property (@(posedge clk) disable iff (!arst_n) cmd.cost_step |-> pos_q <= n)
		else $error("cost walk ran past tour");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n) emit_q < n)
		else $error("emit index out of range");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(2*CNT_W)'(load_q) < nn || cfg_we || $past(cfg_we))
		else $error("load index out of range");
endmodule

>>> sv/tsp_exhaustive_search.sv
// Top level of the exhaustive tour search block.
// Depends on tsp_pkg, tsp_ctrl and tsp_dp.
`timescale 1ns / 1ps
// The block takes a city_count by city_count distance matrix in row-major order, one
// entry a cycle on the distance request channel. On the entry that completes the
// matrix it closes the input and searches every tour in lexicographic order from the
// identity tour, keeping the first tour of lowest closed-cycle cost. The cost walk reads one
// matrix entry a cycle from the distance memory. The best tour then leaves one city a
// request with its cost and a last-city flag, and the block returns to loading. Writing
// city_count restarts the matrix load.
module tsp_exhaustive_search import tsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] distance,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  tour_city,
	output logic [18:0] best_cost,
	output logic        last_city
);
	cmd_t  cmd;
	stat_t stat;

	tsp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	tsp_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.distance(distance), .cmd(cmd), .stat(stat), .tour_city(tour_city),
		.best_cost(best_cost), .last_city(last_city)
	);
endmodule
